// ===== rtl/core/bhpq_pkg.sv =====
// Shared constants, entry type and result codes of the binary heap priority queue.
// Depends on nothing; bhpq_cmp and the top level take names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int TAG_WIDTH = 16;
    localparam int KEY_W     = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = ADDR_W + 1;
    localparam int EXT_W     = IDX_W + 1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_WIDTH-1:0]    tag;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/bhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; width and depth come in as parameters.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bhpq_cmp.sv =====
// Shared priority comparator: is key a strictly ahead of key b in the selected order.
// Depends on bhpq_pkg for the key width.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_cmp (
    input  wire logic signed [bhpq_pkg::KEY_W-1:0] a_key,
    input  wire logic signed [bhpq_pkg::KEY_W-1:0] b_key,
    input  wire logic                              max_first,
    output logic                                   ahead
);

    always_comb
    begin
        if (max_first)
        begin
            ahead = (a_key > b_key);
        end
        else
        begin
            ahead = (a_key < b_key);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/binary_heap_priority_queue.sv =====
// Top level of the binary heap priority queue: sequencer, heap RAM and comparator.
// Depends on bhpq_pkg, bhpq_ram and bhpq_cmp.
//
// channel   | handshake            | word
// ----------+----------------------+-----------------------------------------------
// command   | start / busy         | operation, key, value_tag
// result    | done (1-cycle pulse) | popped_*, error_code, top_*, entry_count
// config    | cfg_valid/cfg_ready  | cfg_data (max_first)
//
// A push reads the parent and compares at each level climbed; a pop loads the last
// entry, then reads the left and right child, picks and compares at each level
// descended. The single RAM read port and the one comparator set the pace. Errors
// and the pop of the last entry go straight to the finish state; a new command is
// taken in the done cycle. Reset clears count, order (max first) and the sequencer;
// the RAM holds no reset. Results cannot be stalled: done pulses once.
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  operation,
    input  wire logic signed [31:0]                    key,
    input  wire logic [15:0]                           value_tag,
    output logic                                       done,
    output logic                                       popped_valid,
    output logic signed [31:0]                         popped_key,
    output logic [15:0]                                popped_tag,
    output logic [1:0]                                 error_code,
    output logic                                       top_valid,
    output logic signed [31:0]                         top_key,
    output logic [15:0]                                top_tag,
    output logic [6:0]                                 entry_count,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic                                  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_PICK,
        S_DN_SWAP,
        S_FIN
    } state_t;

    state_t                              state_reg;
    logic                                busy_reg;
    logic                                done_reg;
    logic                                max_first_reg;
    logic [bhpq_pkg::CNT_W-1:0]          count_reg;
    logic [bhpq_pkg::ADDR_W-1:0]         pos_reg;
    logic [bhpq_pkg::ADDR_W-1:0]         pick_addr_reg;
    logic                                has_right_reg;
    bhpq_pkg::entry_t                    carry_reg;
    bhpq_pkg::entry_t                    left_reg;
    bhpq_pkg::entry_t                    pick_reg;
    bhpq_pkg::entry_t                    top_reg;
    bhpq_pkg::entry_t                    popped_reg;
    logic                                popped_valid_reg;
    bhpq_pkg::err_t                      err_reg;

    logic                                ram_we;
    logic [bhpq_pkg::ADDR_W-1:0]         ram_waddr;
    bhpq_pkg::entry_t                    ram_wdata;
    logic [bhpq_pkg::ADDR_W-1:0]         ram_raddr;
    bhpq_pkg::entry_t                    ram_rdata;

    logic signed [bhpq_pkg::KEY_W-1:0]   cmp_a;
    logic signed [bhpq_pkg::KEY_W-1:0]   cmp_b;
    logic                                cmp_ahead;

    logic [bhpq_pkg::ADDR_W-1:0]         parent_idx;
    logic [bhpq_pkg::EXT_W-1:0]          left_idx;
    logic [bhpq_pkg::EXT_W-1:0]          right_idx;
    logic [bhpq_pkg::EXT_W-1:0]          cnt_ext;

    bhpq_ram #(
        .WIDTH ($bits(bhpq_pkg::entry_t)),
        .DEPTH (bhpq_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bhpq_cmp u_cmp (
        .a_key     (cmp_a),
        .b_key     (cmp_b),
        .max_first (max_first_reg),
        .ahead     (cmp_ahead)
    );

    assign parent_idx = (pos_reg - bhpq_pkg::ADDR_W'(1)) >> 1;
    assign left_idx   = bhpq_pkg::EXT_W'({pos_reg, 1'b1});
    assign right_idx  = left_idx + bhpq_pkg::EXT_W'(1);
    assign cnt_ext    = bhpq_pkg::EXT_W'(count_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = carry_reg;
        ram_raddr = '0;
        cmp_a     = carry_reg.key;
        cmp_b     = ram_rdata.key;
        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = bhpq_pkg::ADDR_W'(count_reg - bhpq_pkg::CNT_W'(1));
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr = parent_idx;
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_ahead)
                begin
                    ram_wdata = ram_rdata;
                end
            end
            S_DN_RDL:
            begin
                if (left_idx >= cnt_ext)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr = left_idx[bhpq_pkg::ADDR_W-1:0];
                end
            end
            S_DN_RDR:
            begin
                ram_raddr = right_idx[bhpq_pkg::ADDR_W-1:0];
            end
            S_DN_PICK:
            begin
                cmp_a = ram_rdata.key;
                cmp_b = left_reg.key;
            end
            S_DN_SWAP:
            begin
                cmp_a  = pick_reg.key;
                cmp_b  = carry_reg.key;
                ram_we = 1'b1;
                if (cmp_ahead)
                begin
                    ram_wdata = pick_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            busy_reg         <= 1'b0;
            done_reg         <= 1'b0;
            max_first_reg    <= 1'b1;
            count_reg        <= '0;
            popped_valid_reg <= 1'b0;
            err_reg          <= bhpq_pkg::ERR_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                max_first_reg <= cfg_data;
            end
            if (ram_we && (ram_waddr == '0))
            begin
                top_reg <= ram_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        busy_reg         <= 1'b1;
                        popped_valid_reg <= 1'b0;
                        popped_reg       <= '0;
                        err_reg          <= bhpq_pkg::ERR_OK;
                        state_reg        <= S_FIN;
                        if (operation == bhpq_pkg::OP_PUSH)
                        begin
                            if (count_reg == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY))
                            begin
                                err_reg <= bhpq_pkg::ERR_FULL;
                            end
                            else
                            begin
                                carry_reg.key <= key;
                                carry_reg.tag <= bhpq_pkg::TAG_WIDTH'(value_tag);
                                pos_reg       <= bhpq_pkg::ADDR_W'(count_reg);
                                count_reg     <= count_reg + bhpq_pkg::CNT_W'(1);
                                state_reg     <= S_UP_RD;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            err_reg <= bhpq_pkg::ERR_EMPTY;
                        end
                        else
                        begin
                            popped_valid_reg <= 1'b1;
                            popped_reg       <= top_reg;
                            count_reg        <= count_reg - bhpq_pkg::CNT_W'(1);
                            if (count_reg != bhpq_pkg::CNT_W'(1))
                            begin
                                state_reg <= S_DN_LOAD;
                            end
                        end
                    end
                end
                S_UP_RD:
                begin
                    if (pos_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_UP_CMP;
                    end
                end
                S_UP_CMP:
                begin
                    if (cmp_ahead)
                    begin
                        pos_reg   <= parent_idx;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_DN_LOAD:
                begin
                    carry_reg <= ram_rdata;
                    pos_reg   <= '0;
                    state_reg <= S_DN_RDL;
                end
                S_DN_RDL:
                begin
                    if (left_idx >= cnt_ext)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_DN_RDR;
                    end
                end
                S_DN_RDR:
                begin
                    left_reg      <= ram_rdata;
                    has_right_reg <= (right_idx < cnt_ext);
                    state_reg     <= S_DN_PICK;
                end
                S_DN_PICK:
                begin
                    if (has_right_reg && cmp_ahead)
                    begin
                        pick_reg      <= ram_rdata;
                        pick_addr_reg <= right_idx[bhpq_pkg::ADDR_W-1:0];
                    end
                    else
                    begin
                        pick_reg      <= left_reg;
                        pick_addr_reg <= left_idx[bhpq_pkg::ADDR_W-1:0];
                    end
                    state_reg <= S_DN_SWAP;
                end
                S_DN_SWAP:
                begin
                    if (cmp_ahead)
                    begin
                        pos_reg   <= pick_addr_reg;
                        state_reg <= S_DN_RDL;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = busy_reg;
    assign cfg_ready    = !busy_reg;
    assign done         = done_reg;
    assign popped_valid = popped_valid_reg;
    assign popped_key   = popped_reg.key;
    assign popped_tag   = 16'(popped_reg.tag);
    assign error_code   = err_reg;
    assign top_valid    = (count_reg != '0);
    assign top_key      = top_valid ? top_reg.key : '0;
    assign top_tag      = top_valid ? 16'(top_reg.tag) : '0;
    assign entry_count  = 7'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (error_code == bhpq_pkg::ERR_FULL)) |->
            (count_reg == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY)))
        else $error("full error reported below capacity");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (error_code == bhpq_pkg::ERR_EMPTY)) |-> (!popped_valid && !top_valid))
        else $error("empty pop reported an entry");

endmodule

`default_nettype wire
